@@ hw/rtl/stl_pkg.sv @@
// shared types and constants for the script token lexer
`timescale 1ns / 1ps
package stl_pkg;

  localparam int unsigned LineBitsDef = 16;
  localparam int unsigned KwNum = 12;
  localparam int unsigned MaxRes = 5;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [14:0] {
    PH_IDLE    = 15'h0001,
    PH_SLASH   = 15'h0002,
    PH_EQ      = 15'h0004,
    PH_BANG    = 15'h0008,
    PH_LT      = 15'h0010,
    PH_GT      = 15'h0020,
    PH_AMP     = 15'h0040,
    PH_PIPE    = 15'h0080,
    PH_IDENT   = 15'h0100,
    PH_NUM     = 15'h0200,
    PH_NUMDOT  = 15'h0400,
    PH_FRAC    = 15'h0800,
    PH_STR     = 15'h1000,
    PH_ESC     = 15'h2000,
    PH_COMMENT = 15'h4000
  } phase_e;

  localparam logic [5:0] KEnd     = 6'd0;
  localparam logic [5:0] KIdent   = 6'd1;
  localparam logic [5:0] KNumber  = 6'd2;
  localparam logic [5:0] KString  = 6'd3;
  localparam logic [5:0] KKw0     = 6'd4;
  localparam logic [5:0] KLParen  = 6'd16;
  localparam logic [5:0] KRParen  = 6'd17;
  localparam logic [5:0] KLBrace  = 6'd18;
  localparam logic [5:0] KRBrace  = 6'd19;
  localparam logic [5:0] KComma   = 6'd20;
  localparam logic [5:0] KSemi    = 6'd21;
  localparam logic [5:0] KDot     = 6'd22;
  localparam logic [5:0] KPlus    = 6'd23;
  localparam logic [5:0] KMinus   = 6'd24;
  localparam logic [5:0] KStar    = 6'd25;
  localparam logic [5:0] KPercent = 6'd26;
  localparam logic [5:0] KDiv     = 6'd27;
  localparam logic [5:0] KAssign  = 6'd28;
  localparam logic [5:0] KEqEq    = 6'd29;
  localparam logic [5:0] KBang    = 6'd30;
  localparam logic [5:0] KNe      = 6'd31;
  localparam logic [5:0] KLt      = 6'd32;
  localparam logic [5:0] KLe      = 6'd33;
  localparam logic [5:0] KGt      = 6'd34;
  localparam logic [5:0] KGe      = 6'd35;
  localparam logic [5:0] KAndAnd  = 6'd36;
  localparam logic [5:0] KOrOr    = 6'd37;
  localparam logic [5:0] KUnknown = 6'd38;

  typedef struct packed {
    logic       mode;
    logic [7:0] src_byte;
  } req_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  text_byte;
    logic        is_close;
    logic [15:0] line_no;
    logic        last_result;
  } rsp_t;

  // one result without line and last flag
  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] text_byte;
    logic       is_close;
  } res_t;

  // classified batch handed from front to back
  typedef struct packed {
    logic [2:0]             cnt;
    res_t [MaxRes-1:0]      res;
    logic [15:0]            line_no;
  } batch_t;

  function automatic logic [7:0] kw_len(input int unsigned k);
    logic [7:0] l;
    unique case (k)
      0: l = 8'd2;
      1, 2, 7, 10: l = 8'd4;
      3, 4, 5, 6: l = 8'd3;
      8, 11: l = 8'd5;
      default: l = 8'd8;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] p);
    logic [63:0] s;
    logic [7:0]  c;
    unique case (k)
      0: s = {"if", 48'd0};
      1: s = {"elif", 32'd0};
      2: s = {"else", 32'd0};
      3: s = {"for", 40'd0};
      4: s = {"obj", 40'd0};
      5: s = {"num", 40'd0};
      6: s = {"str", 40'd0};
      7: s = {"bool", 32'd0};
      8: s = {"break", 24'd0};
      9: s = "continue";
      10: s = {"true", 32'd0};
      default: s = {"false", 24'd0};
    endcase
    c = 8'd0;
    if (p < 4'd8) c = s[63 - 8*p[2:0] -: 8];
    return c;
  endfunction

endpackage

@@ hw/rtl/script_token_lexer_core.sv @@
// top level of the script token lexer
// a result passes through the queue and then the output register before it is offered
// throughput: one request per cycle while each gives at most one result and the receiver is ready,
// otherwise one result per cycle while the receiver is ready, set by the single output register
// a four-entry queue between lexer and emitter absorbs bursts
// reset: asynchronous, phase idle, line count one, queue and output empty
`timescale 1ns / 1ps
module script_token_lexer_core #(
  parameter int unsigned LineBits = stl_pkg::LineBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  stl_pkg::req_t req_i,
  output logic          valid_o,
  input  logic          ready_i,
  output stl_pkg::rsp_t rsp_o
);

  logic            fv, fr, qv, qr;
  stl_pkg::batch_t fb, qb;

  stl_front #(.LineBits(LineBits)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .req_i,
    .bvalid_o(fv), .bready_i(fr), .batch_o(fb)
  );

  stl_queue u_queue (
    .clk_i, .rst_ni, .wvalid_i(fv), .wready_o(fr), .wdata_i(fb),
    .rvalid_o(qv), .rready_i(qr), .rdata_o(qb)
  );

  stl_back u_back (
    .clk_i, .rst_ni, .bvalid_i(qv), .bready_o(qr), .batch_i(qb),
    .valid_o, .ready_i, .rsp_o
  );

`ifndef SYNTHESIS
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rsp_o.line_no != 16'd0) else $error("line number zero");
  a_close_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.is_close |-> rsp_o.text_byte == 8'd0) else $error("close with text");
  a_text_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !rsp_o.is_close |-> rsp_o.kind == 6'd0) else $error("text with kind");
`endif

endmodule

@@ hw/rtl/stl_front.sv @@
// front end: lexer state machine that turns each request into a batch of results
`timescale 1ns / 1ps
module stl_front #(
  parameter int unsigned LineBits = stl_pkg::LineBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  stl_pkg::req_t   req_i,
  output logic            bvalid_o,
  input  logic            bready_i,
  output stl_pkg::batch_t batch_o
);

  stl_pkg::phase_e     phase_q, phase_d;
  logic [LineBits-1:0] line_q, line_d;
  logic [11:0]         mask_q, mask_d;
  logic [3:0]          len_q, len_d;
  stl_pkg::batch_t     b;
  logic [2:0]          n;
  logic [15:0]         ln_sat;

  assign ready_o  = bready_i;
  assign bvalid_o = valid_i;
  assign batch_o  = b;

  localparam logic [LineBits-1:0] LineMax = '1;

  always_comb begin
    logic [31:0] lw;
    lw = 32'(line_q);
    ln_sat = (lw > 32'h0000FFFF) ? 16'hFFFF : lw[15:0];
  end

  always_comb begin
    logic [7:0] c;
    logic       fl, idl, alpha, digit;
    logic [11:0] m;
    logic [5:0] ik;
    c = req_i.src_byte;
    phase_d = phase_q; line_d = line_q; mask_d = mask_q; len_d = len_q;
    n = '0;
    b = '0;
    fl = 1'b0; idl = 1'b0;
    m = '0; ik = stl_pkg::KIdent;
    alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    digit = c >= "0" && c <= "9";
    if (req_i.mode) begin
      fl = 1'b1;
    end else begin
      unique case (phase_q)
        stl_pkg::PH_SLASH: begin
          if (c == "/") phase_d = stl_pkg::PH_COMMENT;
          else begin fl = 1'b1; idl = 1'b1; end
        end
        stl_pkg::PH_EQ, stl_pkg::PH_BANG, stl_pkg::PH_LT, stl_pkg::PH_GT,
        stl_pkg::PH_AMP, stl_pkg::PH_PIPE: begin
          logic [7:0] f, s;
          logic [5:0] k;
          unique case (phase_q)
            stl_pkg::PH_EQ:   begin f = "="; s = "="; k = stl_pkg::KEqEq; end
            stl_pkg::PH_BANG: begin f = "!"; s = "="; k = stl_pkg::KNe; end
            stl_pkg::PH_LT:   begin f = "<"; s = "="; k = stl_pkg::KLe; end
            stl_pkg::PH_GT:   begin f = ">"; s = "="; k = stl_pkg::KGe; end
            stl_pkg::PH_AMP:  begin f = "&"; s = "&"; k = stl_pkg::KAndAnd; end
            default:          begin f = "|"; s = "|"; k = stl_pkg::KOrOr; end
          endcase
          if (c == s) begin
            b.res[0] = '{6'd0, f, 1'b0};
            b.res[1] = '{6'd0, s, 1'b0};
            b.res[2] = '{k, 8'd0, 1'b1};
            n = 3'd3;
            phase_d = stl_pkg::PH_IDLE;
          end else begin fl = 1'b1; idl = 1'b1; end
        end
        stl_pkg::PH_IDENT: begin
          if (alpha || digit) idl = 1'b1;
          else begin fl = 1'b1; idl = 1'b1; end
        end
        stl_pkg::PH_NUM, stl_pkg::PH_FRAC: begin
          if (digit) begin
            b.res[0] = '{6'd0, c, 1'b0}; n = 3'd1;
          end else if (c == "." && phase_q == stl_pkg::PH_NUM) begin
            phase_d = stl_pkg::PH_NUMDOT;
          end else begin fl = 1'b1; idl = 1'b1; end
        end
        stl_pkg::PH_NUMDOT: begin
          if (digit) begin
            b.res[0] = '{6'd0, 8'h2e, 1'b0};
            b.res[1] = '{6'd0, c, 1'b0};
            n = 3'd2; phase_d = stl_pkg::PH_FRAC;
          end else begin fl = 1'b1; idl = 1'b1; end
        end
        stl_pkg::PH_STR: begin
          if (c == 8'd0) begin
            b.res[0] = '{stl_pkg::KUnknown, 8'd0, 1'b1}; n = 3'd1;
            phase_d = stl_pkg::PH_IDLE;
          end else if (c == 8'h22) begin
            b.res[0] = '{stl_pkg::KString, 8'd0, 1'b1}; n = 3'd1;
            phase_d = stl_pkg::PH_IDLE;
          end else if (c == 8'h5c) begin
            phase_d = stl_pkg::PH_ESC;
          end else begin
            b.res[0] = '{6'd0, c, 1'b0}; n = 3'd1;
          end
        end
        stl_pkg::PH_ESC: begin
          b.res[0] = '{6'd0, (c == "n") ? 8'd10 : ((c == "t") ? 8'd9 : c), 1'b0};
          n = 3'd1; phase_d = stl_pkg::PH_STR;
        end
        stl_pkg::PH_COMMENT: begin
          if (c == 8'h0a) begin
            if (line_q != LineMax) line_d = line_q + 1'b1;
            phase_d = stl_pkg::PH_IDLE;
          end else if (c == 8'd0) idl = 1'b1;
        end
        default: idl = 1'b1;
      endcase
    end

    // keyword kind of the held identifier
    for (int k = stl_pkg::KwNum - 1; k >= 0; k--)
      if (mask_q[k] && stl_pkg::kw_len(k) == {4'd0, len_q})
        ik = stl_pkg::KKw0 + 6'(k);

    if (fl) begin
      unique case (phase_q)
        stl_pkg::PH_SLASH, stl_pkg::PH_EQ, stl_pkg::PH_BANG, stl_pkg::PH_LT,
        stl_pkg::PH_GT, stl_pkg::PH_AMP, stl_pkg::PH_PIPE: begin
          logic [7:0] f;
          logic [5:0] k;
          unique case (phase_q)
            stl_pkg::PH_SLASH: begin f = "/"; k = stl_pkg::KDiv; end
            stl_pkg::PH_EQ:    begin f = "="; k = stl_pkg::KAssign; end
            stl_pkg::PH_BANG:  begin f = "!"; k = stl_pkg::KBang; end
            stl_pkg::PH_LT:    begin f = "<"; k = stl_pkg::KLt; end
            stl_pkg::PH_GT:    begin f = ">"; k = stl_pkg::KGt; end
            default:           begin f = (phase_q == stl_pkg::PH_AMP) ? "&" : "|";
                                     k = stl_pkg::KUnknown; end
          endcase
          b.res[0] = '{6'd0, f, 1'b0};
          b.res[1] = '{k, 8'd0, 1'b1};
          n = 3'd2;
        end
        stl_pkg::PH_IDENT: begin b.res[0] = '{ik, 8'd0, 1'b1}; n = 3'd1; end
        stl_pkg::PH_NUM, stl_pkg::PH_FRAC: begin
          b.res[0] = '{stl_pkg::KNumber, 8'd0, 1'b1}; n = 3'd1;
        end
        stl_pkg::PH_NUMDOT: begin
          b.res[0] = '{stl_pkg::KNumber, 8'd0, 1'b1};
          b.res[1] = '{6'd0, 8'h2e, 1'b0};
          b.res[2] = '{stl_pkg::KDot, 8'd0, 1'b1};
          n = 3'd3;
        end
        stl_pkg::PH_STR, stl_pkg::PH_ESC: begin
          b.res[0] = '{stl_pkg::KUnknown, 8'd0, 1'b1}; n = 3'd1;
        end
        default: ;
      endcase
      phase_d = stl_pkg::PH_IDLE;
    end

    if (req_i.mode) begin
      b.res[n] = '{stl_pkg::KEnd, 8'd0, 1'b1};
      n = n + 3'd1;
      mask_d = '1; len_d = '0;
    end

    if (idl) begin
      logic ext;
      ext = (phase_q == stl_pkg::PH_IDENT) && !fl;
      if (!ext) phase_d = stl_pkg::PH_IDLE;
      if (alpha || (ext && digit)) begin
        logic [11:0] mm;
        logic [3:0]  ll;
        mm = ext ? mask_q : 12'hFFF;
        ll = ext ? len_q : 4'd0;
        for (int k = 0; k < stl_pkg::KwNum; k++)
          m[k] = mm[k] && ({4'd0, ll} < stl_pkg::kw_len(k)) &&
                 (stl_pkg::kw_char(k, ll) == c);
        mask_d = m;
        len_d = (ll != 4'hF) ? ll + 4'd1 : ll;
        b.res[n] = '{6'd0, c, 1'b0}; n = n + 3'd1;
        phase_d = stl_pkg::PH_IDENT;
      end else if (digit) begin
        b.res[n] = '{6'd0, c, 1'b0}; n = n + 3'd1;
        phase_d = stl_pkg::PH_NUM;
      end else begin
        unique case (c)
          8'h20, 8'h09, 8'h0d: ;
          8'h0a: if (line_q != LineMax) line_d = line_q + 1'b1;
          "/": phase_d = stl_pkg::PH_SLASH;
          "=": phase_d = stl_pkg::PH_EQ;
          "!": phase_d = stl_pkg::PH_BANG;
          "<": phase_d = stl_pkg::PH_LT;
          ">": phase_d = stl_pkg::PH_GT;
          "&": phase_d = stl_pkg::PH_AMP;
          "|": phase_d = stl_pkg::PH_PIPE;
          8'h22: phase_d = stl_pkg::PH_STR;
          default: begin
            logic [5:0] k;
            unique case (c)
              "(": k = stl_pkg::KLParen;
              ")": k = stl_pkg::KRParen;
              "{": k = stl_pkg::KLBrace;
              "}": k = stl_pkg::KRBrace;
              ",": k = stl_pkg::KComma;
              ";": k = stl_pkg::KSemi;
              ".": k = stl_pkg::KDot;
              "+": k = stl_pkg::KPlus;
              "-": k = stl_pkg::KMinus;
              "*": k = stl_pkg::KStar;
              "%": k = stl_pkg::KPercent;
              default: k = stl_pkg::KUnknown;
            endcase
            b.res[n] = '{6'd0, c, 1'b0};
            b.res[n + 3'd1] = '{k, 8'd0, 1'b1};
            n = n + 3'd2;
          end
        endcase
      end
    end
    b.cnt = n;
    b.line_no = ln_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stl_pkg::PH_IDLE;
      line_q  <= LineBits'(1);
      mask_q  <= '1;
      len_q   <= '0;
    end else if (valid_i && bready_i) begin
      phase_q <= phase_d;
      line_q  <= line_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
    end
  end

endmodule

@@ hw/rtl/stl_queue.sv @@
// small fifo of classified batches between front and back
`timescale 1ns / 1ps
module stl_queue #(
  parameter int unsigned Depth = stl_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wvalid_i,
  output logic            wready_o,
  input  stl_pkg::batch_t wdata_i,
  output logic            rvalid_o,
  input  logic            rready_i,
  output stl_pkg::batch_t rdata_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  stl_pkg::batch_t     mem_q [Depth];
  logic [Aw-1:0]       wp_q, rp_q;
  logic [Aw:0]         cnt_q;
  logic                we, re;

  assign wready_o = cnt_q != Depth[Aw:0];
  assign rvalid_o = cnt_q != '0;
  assign rdata_o  = mem_q[rp_q];
  assign we = wvalid_i && wready_o;
  assign re = rvalid_o && rready_i;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (we) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (re) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(we) - (Aw+1)'(re);
    end
  end

endmodule

@@ hw/rtl/stl_back.sv @@
// back end: sends the results of each batch one per cycle, while the receiver is ready, into an output register
`timescale 1ns / 1ps
module stl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            bvalid_i,
  output logic            bready_o,
  input  stl_pkg::batch_t batch_i,
  output logic            valid_o,
  input  logic            ready_i,
  output stl_pkg::rsp_t   rsp_o
);

  logic [2:0]    idx_q;
  logic          ov_q;
  stl_pkg::rsp_t o_q;
  logic          load, last, empty;

  assign empty = batch_i.cnt == 3'd0;
  assign load  = !ov_q || ready_i;
  assign last  = (idx_q + 3'd1) >= batch_i.cnt;
  assign bready_o = bvalid_i && (empty || (load && last));
  assign valid_o = ov_q;
  assign rsp_o = o_q;

  always_ff @(posedge clk_i) begin
    if (load && bvalid_i && !empty) begin
      o_q.kind        <= batch_i.res[idx_q].kind;
      o_q.text_byte   <= batch_i.res[idx_q].text_byte;
      o_q.is_close    <= batch_i.res[idx_q].is_close;
      o_q.line_no     <= batch_i.line_no;
      o_q.last_result <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; idx_q <= '0;
    end else if (load) begin
      ov_q <= bvalid_i && !empty;
      if (bvalid_i && !empty) idx_q <= last ? 3'd0 : idx_q + 3'd1;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// testbench for the script token lexer core: scoreboard, stimulus, checks
`timescale 1ns / 1ps
module tb;
  import stl_pkg::*;

  class token_scoreboard;
    rsp_t pending_tokens[$];
    phase_e ph;
    logic [15:0] line_cnt;
    logic [11:0] kw_mask;
    logic [3:0] id_len;
    int mismatches;
    int checked;
    rsp_t batch[$];

    function void clear();
      ph = PH_IDLE;
      line_cnt = 16'd1;
      kw_mask = 12'hfff;
      id_len = 4'd0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void put(logic [5:0] k, logic [7:0] t, logic c);
      rsp_t r;
      if (batch.size() >= 8) return;
      r.kind = k;
      r.text_byte = t;
      r.is_close = c;
      r.line_no = line_cnt;
      r.last_result = 1'b0;
      batch = {batch, r};
    endfunction

    function void tok1(logic [7:0] ch, logic [5:0] k);
      put(6'd0, ch, 1'b0);
      put(k, 8'd0, 1'b1);
    endfunction

    function void line_up();
      if (line_cnt != 16'hffff) line_cnt++;
    endfunction

    function bit alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function bit digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function void ident_char(logic [7:0] b);
      for (int k = 0; k < KwNum; k++) begin
        if (id_len >= kw_len(k) || kw_char(k, id_len) != b) kw_mask[k] = 1'b0;
      end
      if (id_len < 4'd15) id_len++;
      put(6'd0, b, 1'b0);
    endfunction

    function logic [5:0] ident_kind();
      for (int k = 0; k < KwNum; k++) begin
        if (kw_mask[k] && kw_len(k) == {4'd0, id_len}) return KKw0 + 6'(k);
      end
      return KIdent;
    endfunction

    function void flush();
      case (ph)
        PH_SLASH: tok1("/", KDiv);
        PH_EQ: tok1("=", KAssign);
        PH_BANG: tok1("!", KBang);
        PH_LT: tok1("<", KLt);
        PH_GT: tok1(">", KGt);
        PH_AMP: tok1("&", KUnknown);
        PH_PIPE: tok1("|", KUnknown);
        PH_IDENT: put(ident_kind(), 8'd0, 1'b1);
        PH_NUM, PH_FRAC: put(KNumber, 8'd0, 1'b1);
        PH_NUMDOT: begin
          put(KNumber, 8'd0, 1'b1);
          tok1(".", KDot);
        end
        PH_STR, PH_ESC: put(KUnknown, 8'd0, 1'b1);
        default: ;
      endcase
      ph = PH_IDLE;
    endfunction

    function void idle_byte(logic [7:0] b);
      ph = PH_IDLE;
      case (b)
        " ", 8'd9, 8'd13: return;
        8'd10: begin
          line_up();
          return;
        end
        "(": begin tok1(b, KLParen); return; end
        ")": begin tok1(b, KRParen); return; end
        "{": begin tok1(b, KLBrace); return; end
        "}": begin tok1(b, KRBrace); return; end
        ",": begin tok1(b, KComma); return; end
        ";": begin tok1(b, KSemi); return; end
        ".": begin tok1(b, KDot); return; end
        "+": begin tok1(b, KPlus); return; end
        "-": begin tok1(b, KMinus); return; end
        "*": begin tok1(b, KStar); return; end
        "%": begin tok1(b, KPercent); return; end
        "/": begin ph = PH_SLASH; return; end
        "=": begin ph = PH_EQ; return; end
        "!": begin ph = PH_BANG; return; end
        "<": begin ph = PH_LT; return; end
        ">": begin ph = PH_GT; return; end
        "&": begin ph = PH_AMP; return; end
        "|": begin ph = PH_PIPE; return; end
        "\"": begin ph = PH_STR; return; end
        default: ;
      endcase
      if (alpha(b)) begin
        kw_mask = 12'hfff;
        id_len = 4'd0;
        ident_char(b);
        ph = PH_IDENT;
      end else if (digit(b)) begin
        put(6'd0, b, 1'b0);
        ph = PH_NUM;
      end else begin
        tok1(b, KUnknown);
      end
    endfunction

    function void two_char(logic [7:0] b, logic [7:0] first, logic [7:0] second,
                           logic [5:0] k);
      if (b == second) begin
        put(6'd0, first, 1'b0);
        put(6'd0, second, 1'b0);
        put(k, 8'd0, 1'b1);
        ph = PH_IDLE;
      end else begin
        flush();
        idle_byte(b);
      end
    endfunction

    function void note_request(req_t rq);
      logic [7:0] b;
      b = rq.src_byte;
      batch.delete();
      if (rq.mode) begin
        flush();
        put(KEnd, 8'd0, 1'b1);
        kw_mask = 12'hfff;
        id_len = 4'd0;
      end else begin
        case (ph)
          PH_SLASH: begin
            if (b == "/") ph = PH_COMMENT;
            else begin
              flush();
              idle_byte(b);
            end
          end
          PH_EQ: two_char(b, "=", "=", KEqEq);
          PH_BANG: two_char(b, "!", "=", KNe);
          PH_LT: two_char(b, "<", "=", KLe);
          PH_GT: two_char(b, ">", "=", KGe);
          PH_AMP: two_char(b, "&", "&", KAndAnd);
          PH_PIPE: two_char(b, "|", "|", KOrOr);
          PH_IDENT: begin
            if (alpha(b) || digit(b)) ident_char(b);
            else begin
              flush();
              idle_byte(b);
            end
          end
          PH_NUM: begin
            if (digit(b)) put(6'd0, b, 1'b0);
            else if (b == ".") ph = PH_NUMDOT;
            else begin
              flush();
              idle_byte(b);
            end
          end
          PH_NUMDOT: begin
            if (digit(b)) begin
              put(6'd0, ".", 1'b0);
              put(6'd0, b, 1'b0);
              ph = PH_FRAC;
            end else begin
              flush();
              idle_byte(b);
            end
          end
          PH_FRAC: begin
            if (digit(b)) put(6'd0, b, 1'b0);
            else begin
              flush();
              idle_byte(b);
            end
          end
          PH_STR: begin
            if (b == 8'd0) begin
              put(KUnknown, 8'd0, 1'b1);
              ph = PH_IDLE;
            end else if (b == "\"") begin
              put(KString, 8'd0, 1'b1);
              ph = PH_IDLE;
            end else if (b == "\\") ph = PH_ESC;
            else put(6'd0, b, 1'b0);
          end
          PH_ESC: begin
            put(6'd0, b == "n" ? 8'd10 : (b == "t" ? 8'd9 : b), 1'b0);
            ph = PH_STR;
          end
          PH_COMMENT: begin
            if (b == 8'd10) begin
              line_up();
              ph = PH_IDLE;
            end else if (b == 8'd0) idle_byte(b);
          end
          default: idle_byte(b);
        endcase
      end
      if (batch.size() > 0) batch[batch.size()-1].last_result = 1'b1;
      foreach (batch[i]) pending_tokens = {pending_tokens, batch[i]};
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      checked++;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_tokens.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: kind %0d/%0d text %h/%h close %b/%b line %0d/%0d last %b/%b",
                   want.kind, got.kind, want.text_byte, got.text_byte, want.is_close,
                   got.is_close, want.line_no, got.line_no, want.last_result,
                   got.last_result);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  req_t in_req = '0;
  logic in_ready;
  logic out_valid;
  rsp_t out_rsp;

  token_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_sink = 1'b0;
  int sent = 0;

  script_token_lexer_core DUT (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(in_valid), .ready_o(in_ready),
    .req_i(in_req), .valid_o(out_valid), .ready_i(out_ready), .rsp_o(out_rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_req);
    if (rst_n && out_valid && out_ready) sb.check_result(out_rsp);
  end

  // result side: random stall bursts, or a long forced hold
  initial begin
    sb.clear();
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_sink = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  task automatic send_req(logic mode, logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req.mode <= mode;
    in_req.src_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_req(1'b0, s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    string alphabet;
    alphabet = "abefilnorstuxyz_09.+-*/%=!<>&|(){},;\" \\\n\t";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(128, 255));
      default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endcase
  endfunction

  task automatic send_word();
    string words[14];
    words = '{"if ", "elif ", "else(", "for ", "obj;", "num ", "str,",
              "bool ", "break;", "continue ", "true)", "false ",
              "abcdefghijklmnopq ", "x9_ "};
    send_text(words[$urandom_range(0, 13)]);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed
    send_text("if elif else for obj num str bool break continue true false ");
    send_text("== != <= >= && || & | = ! < > / ");
    send_text("12.5 7. 3.x \"a\\n\\t\\\"\\\\\\q\" // note\n");
    send_req(1'b0, 8'd0);
    send_req(1'b0, 8'hff);
    send_req(1'b0, 8'h80);
    send_text("\"open");
    send_req(1'b1, 8'h00);
    send_text("\"\\");
    send_req(1'b1, 8'hff);
    send_text("//x");
    send_req(1'b0, 8'd0);
    send_text("\"z");
    send_req(1'b0, 8'd0);
    send_text("\"\\");
    send_req(1'b0, 8'd0);
    send_req(1'b0, "\"");
    send_text("continuexyzabcdefg+ 5.");
    send_req(1'b1, 8'h00);
    drain();
    // long receiver hold while requests keep coming
    hold_sink = 1'b1;
    send_text("(a+b)*(c-d);;{x,y}");
    drain();
    // random part
    while (sent < 460) begin
      if (sent > 410) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: send_word();
        3: send_text("12.75 ");
        4: send_text("x <= y && z || !w // c\n");
        5: send_text("\"s\\n q\" ");
        6: send_req(1'b1, 8'($urandom_range(0, 255)));
        default: send_req(1'b0, pick_byte());
      endcase
    end
    send_req(1'b1, 8'h00);
    drain();
    repeat (20) @(negedge clk);
    $display("ran %0d requests and checked %0d results", sent, sb.checked);
    $display("keywords, operators, numbers, strings, comments and odd bytes exercised");
    if (sb.mismatches == 0 && sb.pending_tokens.size() == 0) begin
      $display("script_token_lexer_core verification clean");
    end else begin
      $display("script_token_lexer_core verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("script_token_lexer_core verification failed");
    $finish;
  end
endmodule
